FILE: rtl/srt_pkg.sv
// shared types, codes and helpers for the segment reassembly tracker
// no dependencies; imported by srt_ctx_table and segment_reassembly_tracker
package srt_pkg;

  // default sizing
  localparam int CONTEXTS_DEF     = 4;
  localparam int MAX_SEQUENCE_DEF = 15;

  // fixed field widths
  localparam int MAP_BITS = 16;
  localparam int TOTAL_W  = 5;
  localparam int LEN_W    = 16;
  localparam int SRC_W    = 64;
  localparam int CFG_W    = 16;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_BUFFER_SEGMENTS    = 1'b0,
    CFG_MAX_DOCUMENT_BYTES = 1'b1
  } cfg_reg_t;

  // result status codes
  typedef enum logic [3:0] {
    STAT_APPLIED       = 4'd0,
    STAT_DUPLICATE     = 4'd1,
    STAT_NOT_SEGMENTED = 4'd2,
    STAT_RANGE         = 4'd3,
    STAT_FIRST_NOT_ZERO = 4'd4,
    STAT_NO_CONTEXT    = 4'd5,
    STAT_BUFFER_SMALL  = 4'd6,
    STAT_OUT_OF_ORDER  = 4'd7,
    STAT_NOT_FINISHED  = 4'd8,
    STAT_TOO_LARGE     = 4'd9
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  // item kinds
  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_COLLECT = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [15:0] source_sensor;
    logic [7:0]  sequence_number;
    logic [7:0]  total_segments;
    logic [15:0] payload_length;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    status_t     status;
    logic        finished;
    logic [15:0] document_length;
  } out_result_t;

  // one context table entry
  typedef struct packed {
    logic [SRC_W-1:0]    source;
    logic [TOTAL_W-1:0]  total;
    logic [MAP_BITS-1:0] received_map;
    logic [LEN_W-1:0]    length;
  } ctx_rec_t;

  // ones in the n lowest map positions, all ones from MAP_BITS upward
  function automatic logic [MAP_BITS-1:0] low_mask(logic [7:0] n);
    logic [MAP_BITS-1:0] m;
    if (n >= 8'(MAP_BITS)) begin
      m = '1;
    end else begin
      m = (MAP_BITS'(1) << n) - MAP_BITS'(1);
    end
    return m;
  endfunction

  // all advertised segments received
  function automatic logic doc_complete(logic [TOTAL_W-1:0] total,
                                        logic [MAP_BITS-1:0] map);
    logic [MAP_BITS-1:0] m;
    logic                c;
    m = low_mask(8'(total));
    if (total > TOTAL_W'(MAP_BITS)) begin
      c = 1'b0;
    end else begin
      c = ((map & m) == m);
    end
    return c;
  endfunction

endpackage

FILE: rtl/srt_ctx_table.sv
// context table storage: one entry per reassembly context
// one write port, one read port with registered read data; uses srt_pkg
module srt_ctx_table import srt_pkg::*; #(
  parameter int CONTEXTS = CONTEXTS_DEF,
  localparam int IdxW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1
) (
  input  logic            clk,
  input  logic [IdxW-1:0] rd_addr,
  output ctx_rec_t        rd_data,
  input  logic            wr_en,
  input  logic [IdxW-1:0] wr_addr,
  input  ctx_rec_t        wr_data
);

  ctx_rec_t mem [CONTEXTS];
  ctx_rec_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/segment_reassembly_tracker.sv
// segment reassembly tracker top level: sequencer, source scan and decision
// depends on srt_pkg and srt_ctx_table
// the result strobe rises once the scan, drain and decide states are done, taken at the next edge
// a new item is taken only after the previous result is registered; the scan reads one context per cycle
// busy is high from the cycle after a start transfer until the result is registered
// synchronous active-low reset frees all contexts and restores register defaults
// the result strobe lasts one cycle and cannot be held off by the receiver
module segment_reassembly_tracker import srt_pkg::*; #(
  parameter int CONTEXTS     = CONTEXTS_DEF,
  parameter int MAX_SEQUENCE = MAX_SEQUENCE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  output logic             out_strobe,
  output out_result_t      out_result,
  input  logic             cfg_we,
  input  cfg_reg_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int IdxW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;

  state_t state_r, state_nxt;

  logic [TOTAL_W-1:0] buffer_segments_r;
  logic [LEN_W-1:0]   max_document_bytes_r;

  in_item_t           item_r;
  logic [CONTEXTS-1:0] in_use_r, in_use_nxt;
  logic [IdxW-1:0]    cnt_r, cnt_nxt;
  logic [IdxW-1:0]    rd_idx_r;
  logic               cmp_vld_r;

  logic               hit_r, hit_nxt;
  logic [IdxW-1:0]    hit_idx_r, hit_idx_nxt;
  ctx_rec_t           hit_rec_r, hit_rec_nxt;
  logic               free_r, free_nxt;
  logic [IdxW-1:0]    free_idx_r, free_idx_nxt;

  out_result_t        out_result_r, out_result_nxt;
  logic               out_strobe_r, out_strobe_nxt;

  ctx_rec_t           rd_data;
  logic               tbl_we;
  logic [IdxW-1:0]    tbl_waddr;
  ctx_rec_t           tbl_wdata;

  logic [SRC_W-1:0]   key;
  logic               accept;

  // decision helpers
  logic [7:0]          seq;
  logic [7:0]          tot;
  logic                seq_in_map;
  logic [MAP_BITS-1:0] seq_bit;
  logic [MAP_BITS-1:0] new_map;
  logic [LEN_W:0]      len_sum;
  logic [LEN_W-1:0]    len_sat;
  logic                hit_complete;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign key    = {item_r.source_address, item_r.source_port, item_r.source_sensor};

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

  srt_ctx_table #(
    .CONTEXTS(CONTEXTS)
  ) u_table (
    .clk     (clk),
    .rd_addr (cnt_r),
    .rd_data (rd_data),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_segments_r    <= TOTAL_W'(16);
      max_document_bytes_r <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUFFER_SEGMENTS:    buffer_segments_r    <= cfg_wdata[TOTAL_W-1:0];
        CFG_MAX_DOCUMENT_BYTES: max_document_bytes_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_use_r     <= '0;
      hit_r        <= 1'b0;
      free_r       <= 1'b0;
      cmp_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_use_r     <= in_use_nxt;
      hit_r        <= hit_nxt;
      free_r       <= free_nxt;
      cmp_vld_r    <= (state_r == S_SCAN);
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload and index registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    cnt_r        <= cnt_nxt;
    rd_idx_r     <= cnt_r;
    hit_idx_r    <= hit_idx_nxt;
    hit_rec_r    <= hit_rec_nxt;
    free_idx_r   <= free_idx_nxt;
    out_result_r <= out_result_nxt;
  end

  // decision datapath on the latched item and the scan findings
  always_comb begin
    seq          = item_r.sequence_number;
    tot          = item_r.total_segments;
    seq_in_map   = (seq < 8'(MAP_BITS));
    seq_bit      = seq_in_map ? (MAP_BITS'(1) << seq[3:0]) : '0;
    new_map      = (hit_r ? hit_rec_r.received_map : '0) | seq_bit;
    len_sum      = {1'b0, (hit_r ? hit_rec_r.length : LEN_W'(0))}
                 + {1'b0, item_r.payload_length};
    len_sat      = len_sum[LEN_W] ? '1 : len_sum[LEN_W-1:0];
    hit_complete = hit_r && doc_complete(hit_rec_r.total, hit_rec_r.received_map);
  end

  // sequencer: scan, decide, write back, report
  always_comb begin
    state_nxt      = state_r;
    in_use_nxt     = in_use_r;
    cnt_nxt        = cnt_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_rec_nxt    = hit_rec_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    out_result_nxt = out_result_r;
    out_strobe_nxt = 1'b0;
    tbl_we         = 1'b0;
    tbl_waddr      = hit_idx_r;
    tbl_wdata      = hit_rec_r;

    // source compare on the entry read in the previous cycle
    if (cmp_vld_r && !hit_r && in_use_r[rd_idx_r] && (rd_data.source == key)) begin
      hit_nxt     = 1'b1;
      hit_idx_nxt = rd_idx_r;
      hit_rec_nxt = rd_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt   = '0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // lowest free context
        if (!free_r && !in_use_r[cnt_r]) begin
          free_nxt     = 1'b1;
          free_idx_nxt = cnt_r;
        end
        if (cnt_r == IdxW'(CONTEXTS - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + IdxW'(1);
        end
      end

      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end

      S_DECIDE: begin
        state_nxt                      = S_IDLE;
        out_strobe_nxt                 = 1'b1;
        out_result_nxt.document_length = '0;
        out_result_nxt.finished        = hit_complete;
        out_result_nxt.status          = STAT_APPLIED;

        if (item_r.kind == KIND_SEGMENT) begin
          priority if ((seq > 8'(MAX_SEQUENCE)) || (tot > 8'(MAX_SEQUENCE))
                       || (tot == 8'd0)) begin
            out_result_nxt.status = STAT_NOT_SEGMENTED;
          end else if (seq >= tot) begin
            out_result_nxt.status = STAT_RANGE;
          end else if (!hit_r) begin
            priority if (seq != 8'd0) begin
              out_result_nxt.status = STAT_FIRST_NOT_ZERO;
            end else if (!free_r) begin
              out_result_nxt.status = STAT_NO_CONTEXT;
            end else if (tot > 8'(buffer_segments_r)) begin
              out_result_nxt.status = STAT_BUFFER_SMALL;
            end else begin
              // allocate a fresh context
              tbl_we                   = 1'b1;
              tbl_waddr                = free_idx_r;
              tbl_wdata.source         = key;
              tbl_wdata.total          = tot[TOTAL_W-1:0];
              tbl_wdata.received_map   = new_map;
              tbl_wdata.length         = len_sat;
              in_use_nxt[free_idx_r]   = 1'b1;
              out_result_nxt.finished  = doc_complete(tot[TOTAL_W-1:0], new_map);
            end
          end else if (seq_in_map && hit_rec_r.received_map[seq[3:0]]) begin
            out_result_nxt.status = STAT_DUPLICATE;
          end else if (hit_rec_r.received_map != low_mask(seq)) begin
            out_result_nxt.status = STAT_OUT_OF_ORDER;
          end else begin
            // in-order segment of a known source
            tbl_we                  = 1'b1;
            tbl_waddr               = hit_idx_r;
            tbl_wdata.received_map  = new_map;
            tbl_wdata.length        = len_sat;
            out_result_nxt.finished = doc_complete(hit_rec_r.total, new_map);
          end
        end else begin
          // collect
          if (!hit_complete) begin
            out_result_nxt.status = STAT_NOT_FINISHED;
          end else begin
            in_use_nxt[hit_idx_r] = 1'b0;
            if (hit_rec_r.length > max_document_bytes_r) begin
              out_result_nxt.status = STAT_TOO_LARGE;
            end else begin
              out_result_nxt.document_length = hit_rec_r.length;
            end
          end
        end

        out_result_nxt.ok = (out_result_nxt.status == STAT_APPLIED)
                         || (out_result_nxt.status == STAT_DUPLICATE);
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: tb/srt_checker.sv
// checker for the segment reassembly tracker: watches item, result and register transfers
// keeps its own context table, predicts every result and compares it; depends on srt_pkg
`timescale 1ns / 1ps

module srt_checker import srt_pkg::*; #(
  parameter int CONTEXTS     = CONTEXTS_DEF,
  parameter int MAX_SEQUENCE = MAX_SEQUENCE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  in_item_t         in_item,
  input  logic             out_strobe,
  input  out_result_t      out_result,
  input  logic             cfg_we,
  input  cfg_reg_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               mismatches,
  output int               pending_results
);

  // shadow context table
  logic                slot_busy   [CONTEXTS];
  logic [SRC_W-1:0]    slot_source [CONTEXTS];
  logic [TOTAL_W-1:0]  slot_total  [CONTEXTS];
  logic [MAP_BITS-1:0] slot_map    [CONTEXTS];
  logic [LEN_W-1:0]    slot_length [CONTEXTS];

  // shadow registers
  logic [4:0]  buf_segments;
  logic [15:0] doc_limit;

  // results predicted but not yet seen, oldest first
  out_result_t awaited_results[$];

  // lowest context in use for this source, -1 when none
  function automatic int find_slot(logic [SRC_W-1:0] key);
    int hit;
    hit = -1;
    for (int i = CONTEXTS - 1; i >= 0; i--) begin
      if (slot_busy[i] && slot_source[i] == key) hit = i;
    end
    return hit;
  endfunction

  // every advertised segment of the context received
  function automatic logic slot_all_in(int c);
    logic full;
    full = (c >= 0);
    if (full) begin
      for (int i = 0; i < int'(slot_total[c]); i++) begin
        if (i >= MAP_BITS || !slot_map[c][i]) full = 1'b0;
      end
    end
    return full;
  endfunction

  // map holds exactly the segments below seq
  function automatic logic fills_next_gap(int seq, logic [MAP_BITS-1:0] map);
    logic good;
    good = 1'b1;
    for (int i = 0; i < MAP_BITS; i++) begin
      if ((i < seq) != map[i]) good = 1'b0;
    end
    return good;
  endfunction

  // checks one segment in order and applies it to the table
  function automatic status_t apply_segment(in_item_t it);
    logic [SRC_W-1:0] key;
    logic [LEN_W:0]   sum;
    int seq;
    int tot;
    int c;
    int spare;
    key = {it.source_address, it.source_port, it.source_sensor};
    seq = int'(it.sequence_number);
    tot = int'(it.total_segments);
    if (seq > MAX_SEQUENCE || tot > MAX_SEQUENCE || tot == 0) return STAT_NOT_SEGMENTED;
    if (seq + 1 > tot) return STAT_RANGE;
    c = find_slot(key);
    if (c < 0) begin
      if (seq != 0) return STAT_FIRST_NOT_ZERO;
      spare = -1;
      for (int i = CONTEXTS - 1; i >= 0; i--) begin
        if (!slot_busy[i]) spare = i;
      end
      if (spare < 0) return STAT_NO_CONTEXT;
      if (tot > int'(buf_segments)) return STAT_BUFFER_SMALL;
      c = spare;
      slot_busy[c]   = 1'b1;
      slot_source[c] = key;
      slot_total[c]  = TOTAL_W'(tot);
      slot_map[c]    = '0;
      slot_length[c] = '0;
    end else begin
      if (seq < MAP_BITS && slot_map[c][seq]) return STAT_DUPLICATE;
      if (!fills_next_gap(seq, slot_map[c])) return STAT_OUT_OF_ORDER;
    end
    if (seq < MAP_BITS) slot_map[c][seq] = 1'b1;
    // length saturates at the top of its range
    sum = {1'b0, slot_length[c]} + {1'b0, it.payload_length};
    slot_length[c] = sum[LEN_W] ? '1 : sum[LEN_W-1:0];
    return STAT_APPLIED;
  endfunction

  // expected result of one item, updating the shadow table
  function automatic out_result_t track_item(in_item_t it);
    out_result_t r;
    logic [SRC_W-1:0] key;
    int c;
    key = {it.source_address, it.source_port, it.source_sensor};
    r = '0;
    if (it.kind == KIND_SEGMENT) begin
      r.status   = apply_segment(it);
      r.finished = slot_all_in(find_slot(key));
    end else begin
      c = find_slot(key);
      if (!slot_all_in(c)) begin
        r.status = STAT_NOT_FINISHED;
      end else begin
        r.finished = 1'b1;
        if (slot_length[c] > doc_limit) begin
          r.status = STAT_TOO_LARGE;
        end else begin
          r.status          = STAT_APPLIED;
          r.document_length = slot_length[c];
        end
        slot_busy[c] = 1'b0;
      end
    end
    r.ok = (r.status == STAT_APPLIED || r.status == STAT_DUPLICATE);
    return r;
  endfunction

  // watch all three channels at the rising edge
  always @(posedge clk) begin
    out_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < CONTEXTS; i++) slot_busy[i] = 1'b0;
      buf_segments = 5'd16;
      doc_limit    = 16'hFFFF;
      awaited_results.delete();
      mismatches = 0;
    end else begin
      // register write
      if (cfg_we) begin
        case (cfg_index)
          CFG_BUFFER_SEGMENTS:    buf_segments = cfg_wdata[4:0];
          CFG_MAX_DOCUMENT_BYTES: doc_limit = cfg_wdata[15:0];
          default: ;
        endcase
      end
      // result transfer against the oldest prediction
      if (out_strobe) begin
        if (awaited_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual ok=%0b status=%0d",
                   $time, out_result.ok, out_result.status);
          $display("  finished=%0b length=%0d", out_result.finished,
                   out_result.document_length);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_result.ok !== want.ok || out_result.status !== want.status ||
              out_result.finished !== want.finished ||
              out_result.document_length !== want.document_length) begin
            $display("%0t ns: result mismatch, expected ok=%0b status=%0d finished=%0b len=%0d",
                     $time, want.ok, want.status, want.finished, want.document_length);
            $display("  actual ok=%0b status=%0d finished=%0b len=%0d", out_result.ok,
                     out_result.status, out_result.finished, out_result.document_length);
            mismatches++;
          end
        end
      end
      // item transfer
      if (start && !busy) awaited_results.push_back(track_item(in_item));
    end
    pending_results = awaited_results.size();
  end

endmodule

FILE: tb/tb.sv
// testbench top for segment_reassembly_tracker: clock, reset, directed and random items
// depends on srt_pkg, the tracker RTL and srt_checker, which predicts and compares
`timescale 1ns / 1ps

module tb import srt_pkg::*; ();

  localparam int POOL             = 6;
  localparam int RANDOM_PER_PHASE = 650;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_item_t         in_item;
  logic             out_strobe;
  out_result_t      out_result;
  logic             cfg_we;
  cfg_reg_t         cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  int               mismatches;
  int               pending_results;

  // sender gap chance in percent per item
  int idle_pct;

  // sources of the current phase and how far each document has been sent
  logic [SRC_W-1:0] pool_key   [POOL];
  int               pool_total [POOL];
  int               pool_next  [POOL];

  segment_reassembly_tracker dut (.*);
  srt_checker u_checker (.*);

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic in_item_t segment_item(logic [SRC_W-1:0] key, int seq, int tot,
                                            logic [15:0] bytes);
    in_item_t it;
    it.kind = KIND_SEGMENT;
    {it.source_address, it.source_port, it.source_sensor} = key;
    it.sequence_number = 8'(seq);
    it.total_segments  = 8'(tot);
    it.payload_length  = bytes;
    return it;
  endfunction

  // segment fields are don't-care on a collect, so fill them with noise
  function automatic in_item_t collect_item(logic [SRC_W-1:0] key);
    in_item_t it;
    it = segment_item(key, $urandom_range(0, 255), $urandom_range(0, 255), 16'($urandom));
    it.kind = KIND_COLLECT;
    return it;
  endfunction

  // half full range to reach saturation, half small
  function automatic logic [15:0] random_bytes();
    return ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
  endfunction

  // one item transfer, with an optional gap before it
  task automatic send(in_item_t it);
    if ($urandom_range(0, 99) < idle_pct) begin
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // wait until every predicted result has come and the block is quiet
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results != 0 || busy) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly in-order documents over a small source pool, plus broken items
  task automatic run_phase(int pct, logic [4:0] segs, logic [15:0] limit);
    int k;
    int pick;
    int seq;
    int tot;
    idle_pct = pct;
    write_reg(CFG_BUFFER_SEGMENTS, CFG_W'(segs));
    write_reg(CFG_MAX_DOCUMENT_BYTES, limit);
    for (int i = 0; i < POOL; i++) begin
      pool_key[i]   = {$urandom, $urandom};
      pool_total[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 4);
      pool_next[i]  = 0;
    end
    pool_total[POOL-1] = MAX_SEQUENCE_DEF;
    repeat (RANDOM_PER_PHASE) begin
      k    = $urandom_range(0, POOL - 1);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // next step of a well-formed document
        if (pool_next[k] < pool_total[k]) begin
          send(segment_item(pool_key[k], pool_next[k], pool_total[k], random_bytes()));
          pool_next[k]++;
        end else begin
          send(collect_item(pool_key[k]));
          pool_next[k] = 0;
        end
      end else if (pick < 80) begin
        // collect at any point
        send(collect_item(pool_key[k]));
      end else begin
        // stray segment; a new document always takes the pool total so it can be closed
        seq = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 255);
        tot = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 255);
        if (seq == 0 && tot >= 1 && tot <= MAX_SEQUENCE_DEF) tot = pool_total[k];
        send(segment_item(pool_key[k], seq, tot, random_bytes()));
      end
    end
    // complete and collect every pool document so all contexts are free again
    for (int i = 0; i < POOL; i++) begin
      for (int s = 0; s < pool_total[i]; s++) begin
        send(segment_item(pool_key[i], s, pool_total[i], random_bytes()));
      end
      send(collect_item(pool_key[i]));
    end
  endtask

  initial begin
    logic [SRC_W-1:0] key_a;
    logic [SRC_W-1:0] key_b;
    logic [SRC_W-1:0] key_c;
    logic [SRC_W-1:0] key_d;
    logic [SRC_W-1:0] key_e;
    logic [SRC_W-1:0] key_f;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_BUFFER_SEGMENTS;
    cfg_wdata = '0;
    idle_pct  = 0;
    key_a = '0;
    key_b = '1;
    key_c = {$urandom, $urandom};
    key_d = {$urandom, $urandom};
    key_e = {$urandom, $urandom};
    key_f = {$urandom, $urandom};
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // format and range errors, first-segment rule
    send(collect_item(key_a));
    send(segment_item(key_a, 0, 0, 16'd1));
    send(segment_item(key_a, 16, 15, 16'd1));
    send(segment_item(key_a, 255, 255, 16'hFFFF));
    send(segment_item(key_a, 3, 3, 16'd1));
    send(segment_item(key_a, 1, 3, 16'd1));
    // document build-up, duplicate, out of order, stored total wins, saturation
    send(segment_item(key_a, 0, 2, 16'hFFFF));
    send(segment_item(key_a, 0, 2, 16'd7));
    send(segment_item(key_b, 0, 3, 16'd0));
    send(segment_item(key_b, 2, 15, 16'd9));
    send(segment_item(key_a, 1, 7, 16'd1));
    send(collect_item(key_b));
    send(collect_item(key_a));
    // fill the table, then one more source finds no context
    send(segment_item(key_c, 0, 1, 16'd5));
    send(segment_item(key_d, 0, 1, 16'd100));
    send(segment_item(key_e, 0, 1, 16'd0));
    send(segment_item(key_f, 0, 1, 16'd3));
    send(collect_item(key_c));
    // buffer too small, document too large, empty document at zero limit
    write_reg(CFG_BUFFER_SEGMENTS, CFG_W'(1));
    send(segment_item(key_f, 0, 2, 16'd3));
    write_reg(CFG_MAX_DOCUMENT_BYTES, CFG_W'(0));
    send(collect_item(key_d));
    send(collect_item(key_e));
    write_reg(CFG_BUFFER_SEGMENTS, CFG_W'(0));
    send(segment_item(key_f, 0, 1, 16'd3));
    write_reg(CFG_BUFFER_SEGMENTS, CFG_W'(16));
    write_reg(CFG_MAX_DOCUMENT_BYTES, 16'hFFFF);
    send(segment_item(key_b, 1, 3, 16'd20));
    send(segment_item(key_b, 2, 3, 16'd30));
    send(collect_item(key_b));

    // random phases: light sender gaps, heavy gaps, then back to back
    run_phase(19, 5'($urandom_range(8, 31)), 16'($urandom_range(20000, 65535)));
    run_phase(72, 5'($urandom_range(1, 16)), 16'($urandom_range(0, 65535)));
    run_phase(0, 5'd16, 16'hFFFF);

    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
